FILE: hdl/pm0_pkg.sv
package pm0_pkg;

  localparam int WORD_BITS   = 32;
  localparam int CODE_AW     = 9;
  localparam int CODE_DEPTH  = 512;
  localparam int STACK_AW    = 11;
  localparam int STACK_DEPTH = 2048;
  localparam int IDX_W       = WORD_BITS + 2;

  localparam logic [STACK_AW-1:0] STACK_MAX = STACK_AW'(STACK_DEPTH - 1);

  typedef logic [WORD_BITS-1:0] word_t;

  // Opcodes.
  localparam logic [3:0] OP_LIT = 4'd1;
  localparam logic [3:0] OP_OPR = 4'd2;
  localparam logic [3:0] OP_LOD = 4'd3;
  localparam logic [3:0] OP_STO = 4'd4;
  localparam logic [3:0] OP_CAL = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JPC = 4'd8;
  localparam logic [3:0] OP_SIO = 4'd9;

  // OPR and SIO subcodes.
  localparam word_t OPR_RET = 32'd0;
  localparam word_t OPR_NEG = 32'd1;
  localparam word_t OPR_ADD = 32'd2;
  localparam word_t OPR_SUB = 32'd3;
  localparam word_t OPR_MUL = 32'd4;
  localparam word_t OPR_DIV = 32'd5;
  localparam word_t OPR_ODD = 32'd6;
  localparam word_t OPR_MOD = 32'd7;
  localparam word_t OPR_EQL = 32'd8;
  localparam word_t OPR_NEQ = 32'd9;
  localparam word_t OPR_LSS = 32'd10;
  localparam word_t OPR_LEQ = 32'd11;
  localparam word_t OPR_GTR = 32'd12;
  localparam word_t OPR_GEQ = 32'd13;
  localparam word_t SIO_WRITE = 32'd1;
  localparam word_t SIO_READ  = 32'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
  localparam logic [1:0] ERR_RANGE    = 2'd2;
  localparam logic [1:0] ERR_BAD_OP   = 2'd3;

  localparam logic REQ_LOAD = 1'b0;

  typedef struct packed {
    logic                        req_type;
    logic [CODE_AW-1:0]          code_addr;
    logic [3:0]                  code_op;
    logic [3:0]                  code_level;
    logic signed [WORD_BITS-1:0] code_m;
    logic signed [WORD_BITS-1:0] in_value;
  } req_t;

  typedef struct packed {
    logic [CODE_AW-1:0]          pc_now;
    logic [STACK_AW-1:0]         bp_now;
    logic [STACK_AW-1:0]         sp_now;
    logic                        out_valid;
    logic signed [WORD_BITS-1:0] out_value;
    logic                        in_used;
    logic                        halted;
    logic [1:0]                  error_code;
  } rsp_t;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] level;
    word_t      m;
  } code_word_t;

  typedef struct packed {
    logic               we;
    logic [CODE_AW-1:0] waddr;
    code_word_t         wdata;
    logic               re;
    logic [CODE_AW-1:0] raddr;
  } code_port_t;

  typedef struct packed {
    logic                we;
    logic [STACK_AW-1:0] waddr;
    word_t               wdata;
    logic                re;
    logic [STACK_AW-1:0] raddr;
  } stk_port_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_WALK_WAIT,
    ST_LOD_WR,
    ST_STO_WR,
    ST_CAL_2,
    ST_CAL_3,
    ST_TOP,
    ST_SECOND,
    ST_DIV,
    ST_RET_1,
    ST_RET_2,
    ST_RESP
  } state_t;

endpackage

FILE: hdl/pm0_stack_machine_top.sv
// PM/0 p-code machine. A load request writes one code word and answers through the
// response state and the output register. A step request runs the instruction at pc;
// LIT, INC, JMP and SIO read need no stack read, while LOD, STO and CAL first follow
// one static link per level. DIV and MOD use the divider, which forms one quotient
// bit per cycle, and skip it when the divisor is zero. The pace is set by the single
// read port of the data stack memory, whose read data is registered. After reset the
// stack is swept to zero, during which no request is taken. A result waits in an
// output register, so the next request can be taken while it is pending.
module pm0_stack_machine_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  pm0_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output pm0_pkg::rsp_t   rsp
);
  import pm0_pkg::*;

  code_port_t code_port;
  code_word_t code_q;
  stk_port_t  stk;
  word_t      stk_q;
  logic       res_valid;
  logic       res_ready;
  rsp_t       res;
  logic       div_start;
  logic       div_mod;
  word_t      div_a;
  word_t      div_b;
  logic       div_done;
  word_t      div_res;

  assign res_ready = !rsp_valid || !rsp_stall;

  pm0_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .code_port (code_port),
    .code_q    (code_q),
    .stk       (stk),
    .stk_q     (stk_q),
    .div_start (div_start),
    .div_mod   (div_mod),
    .div_a     (div_a),
    .div_b     (div_b),
    .div_done  (div_done),
    .div_res   (div_res)
  );

  pm0_code_mem u_code_mem (
    .clk   (clk),
    .port  (code_port),
    .rdata (code_q)
  );

  pm0_stack_mem u_stack_mem (
    .clk   (clk),
    .port  (stk),
    .rdata (stk_q)
  );

  pm0_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .is_mod   (div_mod),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .result   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      rsp <= res;
    end
  end

endmodule

FILE: hdl/pm0_code_mem.sv
module pm0_code_mem (
  input  logic                clk,
  input  pm0_pkg::code_port_t port,
  output pm0_pkg::code_word_t rdata
);
  import pm0_pkg::*;

  code_word_t mem [CODE_DEPTH];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    if (port.re) begin
      rdata <= mem[port.raddr];
    end
  end

endmodule

FILE: hdl/pm0_stack_mem.sv
module pm0_stack_mem (
  input  logic               clk,
  input  pm0_pkg::stk_port_t port,
  output pm0_pkg::word_t     rdata
);
  import pm0_pkg::*;

  word_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    if (port.re) begin
      rdata <= mem[port.raddr];
    end
  end

endmodule

FILE: hdl/pm0_divider.sv
module pm0_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           is_mod,
  input  pm0_pkg::word_t dividend,
  input  pm0_pkg::word_t divisor,
  output logic           done,
  output pm0_pkg::word_t result
);
  import pm0_pkg::*;

  localparam int CW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

  logic               busy;
  logic [CW-1:0]      cnt;
  word_t              quo;
  word_t              dmag;
  logic [WORD_BITS:0] rem;
  logic [WORD_BITS:0] rem_sh;
  logic [WORD_BITS:0] diff;
  logic               take;
  logic               neg_a;
  logic               neg_b;
  logic               mod_q;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign rem_sh = {rem[WORD_BITS-1:0], quo[WORD_BITS-1]};
  assign diff   = rem_sh - {1'b0, dmag};
  assign take   = !diff[WORD_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == LAST)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[WORD_BITS-1] ? word_t'(0) - dividend : dividend;
      dmag  <= divisor[WORD_BITS-1] ? word_t'(0) - divisor : divisor;
      rem   <= '0;
      cnt   <= '0;
      neg_a <= dividend[WORD_BITS-1];
      neg_b <= divisor[WORD_BITS-1];
      mod_q <= is_mod;
    end else if (busy) begin
      rem <= take ? diff : rem_sh;
      quo <= {quo[WORD_BITS-2:0], take};
      cnt <= cnt + CW'(1);
    end
  end

  // Truncating division: the remainder takes the sign of the dividend.
  always_comb begin
    if (mod_q) begin
      result = neg_a ? word_t'(0) - rem[WORD_BITS-1:0] : rem[WORD_BITS-1:0];
    end else begin
      result = (neg_a ^ neg_b) ? word_t'(0) - quo : quo;
    end
  end

endmodule

FILE: hdl/pm0_core.sv
module pm0_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  pm0_pkg::req_t       req,
  output logic                res_valid,
  input  logic                res_ready,
  output pm0_pkg::rsp_t       res,
  output pm0_pkg::code_port_t code_port,
  input  pm0_pkg::code_word_t code_q,
  output pm0_pkg::stk_port_t  stk,
  input  pm0_pkg::word_t      stk_q,
  output logic                div_start,
  output logic                div_mod,
  output pm0_pkg::word_t      div_a,
  output pm0_pkg::word_t      div_b,
  input  logic                div_done,
  input  pm0_pkg::word_t      div_res
);
  import pm0_pkg::*;

  state_t              state, state_next;
  logic [CODE_AW-1:0]  pc, pc_next;
  logic [STACK_AW-1:0] bp, bp_next;
  logic [STACK_AW-1:0] sp, sp_next;
  logic                halt, halt_next;
  logic [STACK_AW-1:0] clr_addr;
  word_t               in_q;
  word_t               base_q, base_next;
  logic [3:0]          walk_cnt, walk_cnt_next;
  word_t               top_q, top_next;
  logic [STACK_AW-1:0] idx_q, idx_next;
  logic [1:0]          err_q, err_next;
  logic                outv_q, outv_next;
  word_t               outval_q, outval_next;
  logic                inused_q, inused_next;
  logic                commit;

  logic [3:0]          op;
  logic [3:0]          lvl;
  word_t               cm;
  logic                accept;
  logic [CODE_AW-1:0]  pc_inc;
  logic [CODE_AW-1:0]  mpc;
  logic [STACK_AW-1:0] sp_up, sp_dn;
  logic                sp_full, sp_empty;
  logic                is_bad;
  logic                opr_unary;
  logic                is_divmod;
  logic                ret_ok, cal_ok, inc_ok;
  logic [IDX_W-1:0]    inc_sum;
  logic                base_step_ok, base_idx_ok;
  logic [IDX_W-1:0]    off_sum;
  logic                off_ok, lod_ok, sto_ok;
  logic                nbp_ok;
  word_t               alu_res;
  word_t               odd_res;

  assign op  = code_q.op;
  assign lvl = code_q.level;
  assign cm  = code_q.m;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign res_valid = (state == ST_RESP) && res_ready;

  assign pc_inc   = pc + CODE_AW'(1);
  assign mpc      = cm[CODE_AW-1:0];
  assign sp_up    = sp + STACK_AW'(1);
  assign sp_dn    = sp - STACK_AW'(1);
  assign sp_full  = (sp == STACK_MAX);
  assign sp_empty = (sp == '0);

  assign is_bad = (op < OP_LIT) || (op > OP_SIO) ||
                  ((op == OP_OPR) && (cm > OPR_GEQ)) ||
                  ((op == OP_SIO) && (cm != SIO_WRITE) && (cm != SIO_READ));
  assign opr_unary = (cm == OPR_NEG) || (cm == OPR_ODD);
  assign is_divmod = (cm == OPR_DIV) || (cm == OPR_MOD);

  // A return needs bp - 1 and bp + 2 inside the stack.
  assign ret_ok = (bp != '0) && (bp <= STACK_MAX - STACK_AW'(2));
  assign cal_ok = (sp <= STACK_MAX - STACK_AW'(3));

  assign inc_sum = {{(IDX_W-STACK_AW){1'b0}}, sp} + {{2{cm[WORD_BITS-1]}}, cm};
  assign inc_ok  = (inc_sum[IDX_W-1:STACK_AW] == '0);

  // A link that is followed must be a valid index; the final base may sit one past
  // the top, since the offset can still bring the address back inside.
  assign base_step_ok = (base_q[WORD_BITS-1:STACK_AW] == '0);
  assign base_idx_ok  = !base_q[WORD_BITS-1] && (base_q <= word_t'(STACK_DEPTH));
  assign off_sum = {{2{base_q[WORD_BITS-1]}}, base_q} + {{2{cm[WORD_BITS-1]}}, cm};
  assign off_ok  = base_idx_ok && (off_sum[IDX_W-1:STACK_AW] == '0);
  assign lod_ok  = off_ok && !sp_full;
  assign sto_ok  = off_ok && !sp_empty;
  assign nbp_ok  = (stk_q[WORD_BITS-1:STACK_AW] == '0);

  assign odd_res = stk_q[0] ? (stk_q[WORD_BITS-1] ? '1 : word_t'(1)) : '0;

  // Second operand is the older word (stk_q), first popped is top_q.
  always_comb begin
    case (cm)
      OPR_ADD: alu_res = stk_q + top_q;
      OPR_SUB: alu_res = stk_q - top_q;
      OPR_MUL: alu_res = stk_q * top_q;
      OPR_EQL: alu_res = word_t'(stk_q == top_q);
      OPR_NEQ: alu_res = word_t'(stk_q != top_q);
      OPR_LSS: alu_res = word_t'($signed(stk_q) < $signed(top_q));
      OPR_LEQ: alu_res = word_t'($signed(stk_q) <= $signed(top_q));
      OPR_GTR: alu_res = word_t'($signed(stk_q) > $signed(top_q));
      default: alu_res = word_t'($signed(stk_q) >= $signed(top_q));
    endcase
  end

  assign div_a   = stk_q;
  assign div_b   = top_q;
  assign div_mod = (cm == OPR_MOD);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == STACK_MAX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if ((req.req_type == REQ_LOAD) || halt) begin
            state_next = ST_RESP;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_RESP;
        if (!is_bad) begin
          case (op)
            OP_OPR: begin
              if (cm == OPR_RET) begin
                if (ret_ok) state_next = ST_RET_1;
              end else if (opr_unary || !sp_empty) begin
                state_next = ST_TOP;
              end
            end
            OP_LOD, OP_STO, OP_CAL: state_next = ST_WALK;
            OP_JPC: begin
              if (!sp_empty) state_next = ST_TOP;
            end
            OP_SIO: begin
              if ((cm == SIO_WRITE) && !sp_empty) state_next = ST_TOP;
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_WALK: begin
        state_next = ST_RESP;
        if (walk_cnt != '0) begin
          if (base_step_ok) state_next = ST_WALK_WAIT;
        end else begin
          case (op)
            OP_LOD: begin
              if (lod_ok) state_next = ST_LOD_WR;
            end
            OP_STO: begin
              if (sto_ok) state_next = ST_STO_WR;
            end
            default: begin
              if (cal_ok) state_next = ST_CAL_2;
            end
          endcase
        end
      end
      ST_WALK_WAIT: state_next = ST_WALK;
      ST_LOD_WR:    state_next = ST_RESP;
      ST_STO_WR:    state_next = ST_RESP;
      ST_CAL_2:     state_next = ST_CAL_3;
      ST_CAL_3:     state_next = ST_RESP;
      ST_TOP: begin
        if ((op == OP_OPR) && !opr_unary) begin
          state_next = ST_SECOND;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_SECOND: begin
        if (is_divmod && (top_q != '0)) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_DIV: begin
        if (div_done) state_next = ST_RESP;
      end
      ST_RET_1: begin
        state_next = nbp_ok ? ST_RET_2 : ST_RESP;
      end
      ST_RET_2: state_next = ST_RESP;
      ST_RESP: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath controls and register updates.
  always_comb begin
    pc_next       = pc;
    bp_next       = bp;
    sp_next       = sp;
    halt_next     = halt;
    base_next     = base_q;
    walk_cnt_next = walk_cnt;
    top_next      = top_q;
    idx_next      = idx_q;
    err_next      = err_q;
    outv_next     = outv_q;
    outval_next   = outval_q;
    inused_next   = inused_q;
    commit        = 1'b0;
    code_port     = '0;
    stk           = '0;
    div_start     = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        stk.we    = 1'b1;
        stk.waddr = clr_addr;
      end
      ST_IDLE: begin
        if (accept) begin
          err_next    = ERR_NONE;
          outv_next   = 1'b0;
          outval_next = '0;
          inused_next = 1'b0;
          if (req.req_type == REQ_LOAD) begin
            code_port.we          = 1'b1;
            code_port.waddr       = req.code_addr;
            code_port.wdata.op    = req.code_op;
            code_port.wdata.level = req.code_level;
            code_port.wdata.m     = req.code_m;
          end else if (!halt) begin
            code_port.re    = 1'b1;
            code_port.raddr = pc;
          end
        end
      end
      ST_FETCH: begin
        if (is_bad) begin
          err_next = ERR_BAD_OP;
        end else begin
          case (op)
            OP_LIT: begin
              if (sp_full) begin
                err_next = ERR_RANGE;
              end else begin
                stk.we    = 1'b1;
                stk.waddr = sp_up;
                stk.wdata = cm;
                commit    = 1'b1;
                pc_next   = pc_inc;
                sp_next   = sp_up;
              end
            end
            OP_OPR: begin
              if (cm == OPR_RET) begin
                if (ret_ok) begin
                  stk.re    = 1'b1;
                  stk.raddr = bp + STACK_AW'(1);
                end else begin
                  err_next = ERR_RANGE;
                end
              end else if (opr_unary || !sp_empty) begin
                stk.re    = 1'b1;
                stk.raddr = sp;
              end else begin
                err_next = ERR_RANGE;
              end
            end
            OP_LOD, OP_STO, OP_CAL: begin
              base_next     = word_t'(bp);
              walk_cnt_next = lvl;
            end
            OP_INC: begin
              if (inc_ok) begin
                commit  = 1'b1;
                pc_next = pc_inc;
                sp_next = inc_sum[STACK_AW-1:0];
              end else begin
                err_next = ERR_RANGE;
              end
            end
            OP_JMP: begin
              commit  = 1'b1;
              pc_next = mpc;
            end
            OP_JPC: begin
              if (sp_empty) begin
                err_next = ERR_RANGE;
              end else begin
                stk.re    = 1'b1;
                stk.raddr = sp;
              end
            end
            default: begin
              if (cm == SIO_WRITE) begin
                if (sp_empty) begin
                  err_next = ERR_RANGE;
                end else begin
                  stk.re    = 1'b1;
                  stk.raddr = sp;
                end
              end else if (sp_full) begin
                err_next = ERR_RANGE;
              end else begin
                stk.we      = 1'b1;
                stk.waddr   = sp_up;
                stk.wdata   = in_q;
                inused_next = 1'b1;
                commit      = 1'b1;
                pc_next     = pc_inc;
                sp_next     = sp_up;
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        if (walk_cnt != '0) begin
          if (base_step_ok) begin
            stk.re    = 1'b1;
            stk.raddr = base_q[STACK_AW-1:0];
          end else begin
            err_next = ERR_RANGE;
          end
        end else begin
          case (op)
            OP_LOD: begin
              if (lod_ok) begin
                stk.re    = 1'b1;
                stk.raddr = off_sum[STACK_AW-1:0];
              end else begin
                err_next = ERR_RANGE;
              end
            end
            OP_STO: begin
              if (sto_ok) begin
                stk.re    = 1'b1;
                stk.raddr = sp;
                idx_next  = off_sum[STACK_AW-1:0];
              end else begin
                err_next = ERR_RANGE;
              end
            end
            default: begin
              if (cal_ok) begin
                stk.we    = 1'b1;
                stk.waddr = sp_up;
                stk.wdata = base_q;
              end else begin
                err_next = ERR_RANGE;
              end
            end
          endcase
        end
      end
      ST_WALK_WAIT: begin
        base_next     = stk_q;
        walk_cnt_next = walk_cnt - 4'd1;
      end
      ST_LOD_WR: begin
        stk.we    = 1'b1;
        stk.waddr = sp_up;
        stk.wdata = stk_q;
        commit    = 1'b1;
        pc_next   = pc_inc;
        sp_next   = sp_up;
      end
      ST_STO_WR: begin
        stk.we    = 1'b1;
        stk.waddr = idx_q;
        stk.wdata = stk_q;
        commit    = 1'b1;
        pc_next   = pc_inc;
        sp_next   = sp_dn;
      end
      ST_CAL_2: begin
        stk.we    = 1'b1;
        stk.waddr = sp + STACK_AW'(2);
        stk.wdata = word_t'(bp);
      end
      ST_CAL_3: begin
        stk.we    = 1'b1;
        stk.waddr = sp + STACK_AW'(3);
        stk.wdata = word_t'(pc_inc);
        commit    = 1'b1;
        pc_next   = mpc;
        bp_next   = sp_up;
      end
      ST_TOP: begin
        case (op)
          OP_OPR: begin
            if (cm == OPR_NEG) begin
              stk.we    = 1'b1;
              stk.waddr = sp;
              stk.wdata = word_t'(0) - stk_q;
              commit    = 1'b1;
              pc_next   = pc_inc;
            end else if (cm == OPR_ODD) begin
              stk.we    = 1'b1;
              stk.waddr = sp;
              stk.wdata = odd_res;
              commit    = 1'b1;
              pc_next   = pc_inc;
            end else begin
              top_next  = stk_q;
              stk.re    = 1'b1;
              stk.raddr = sp_dn;
            end
          end
          OP_JPC: begin
            commit  = 1'b1;
            pc_next = (stk_q == '0) ? mpc : pc_inc;
            sp_next = sp_dn;
          end
          default: begin
            outv_next   = 1'b1;
            outval_next = stk_q;
            commit      = 1'b1;
            pc_next     = pc_inc;
            sp_next     = sp_dn;
          end
        endcase
      end
      ST_SECOND: begin
        if (is_divmod && (top_q != '0)) begin
          div_start = 1'b1;
        end else begin
          stk.we    = 1'b1;
          stk.waddr = sp_dn;
          stk.wdata = is_divmod ? '0 : alu_res;
          if (is_divmod) err_next = ERR_DIV_ZERO;
          commit    = 1'b1;
          pc_next   = pc_inc;
          sp_next   = sp_dn;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          stk.we    = 1'b1;
          stk.waddr = sp_dn;
          stk.wdata = div_res;
          commit    = 1'b1;
          pc_next   = pc_inc;
          sp_next   = sp_dn;
        end
      end
      ST_RET_1: begin
        if (nbp_ok) begin
          base_next = stk_q;
          stk.re    = 1'b1;
          stk.raddr = bp + STACK_AW'(2);
        end else begin
          err_next = ERR_RANGE;
        end
      end
      ST_RET_2: begin
        commit  = 1'b1;
        pc_next = stk_q[CODE_AW-1:0];
        sp_next = bp - STACK_AW'(1);
        bp_next = base_q[STACK_AW-1:0];
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase

    if (commit) begin
      halt_next = (pc_next == '0) && (bp_next == '0) && (sp_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      pc       <= '0;
      bp       <= STACK_AW'(1);
      sp       <= '0;
      halt     <= 1'b0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      bp    <= bp_next;
      sp    <= sp_next;
      halt  <= halt_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + STACK_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= req.in_value;
    end
    base_q   <= base_next;
    walk_cnt <= walk_cnt_next;
    top_q    <= top_next;
    idx_q    <= idx_next;
    err_q    <= err_next;
    outv_q   <= outv_next;
    outval_q <= outval_next;
    inused_q <= inused_next;
  end

  always_comb begin
    res.pc_now     = pc;
    res.bp_now     = bp;
    res.sp_now     = sp;
    res.out_valid  = outv_q;
    res.out_value  = outval_q;
    res.in_used    = inused_q;
    res.halted     = halt;
    res.error_code = err_q;
  end

  a_bad_op_no_change: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) && is_bad |=>
      (err_q == ERR_BAD_OP) && (pc == $past(pc)) && (sp == $past(sp)) && (bp == $past(bp)))
    else $error("bad opcode changed the machine registers");

  a_halted_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && accept && (req.req_type != REQ_LOAD) && halt |=>
      (state == ST_RESP) && $stable(pc) && $stable(sp))
    else $error("step request on a halted machine did not answer at once");

  a_stack_one_access: assert property (@(posedge clk) disable iff (rst)
    !(stk.we && stk.re))
    else $error("stack memory read and written in the same cycle");

endmodule
